>>> sv/srsr_pkg.sv
`timescale 1ns / 1ps

package srsr_pkg;

	localparam int SEQ_W = 31;
	localparam int WC_W = 24;
	localparam int DLV_W = 9;

	// received map is stored as rows of this many slots
	localparam int ROW_BITS = 32;
	localparam int ROW_SH = 5;

	// remainder unit: digits per step and step count cover a 32-bit dividend
	localparam int MOD_DIGIT = 8;
	localparam int MOD_STEPS = 4;
	localparam int MOD_SH_W = MOD_DIGIT * MOD_STEPS;
	localparam int MOD_CNT_W = 3;

	typedef struct packed {
		logic [SEQ_W-1:0] seq_num;
		logic             is_fin;
		logic             crc_ok;
	} seg_t;

	typedef struct packed {
		logic [SEQ_W-1:0] ack_num;
		logic [SEQ_W-1:0] sack_num;
		logic             fin_ack;
		logic [DLV_W-1:0] delivered_count;
		logic             done_res;
	} ack_t;

	// segment as held in the queue between front and back
	typedef struct packed {
		logic [SEQ_W-1:0] seq;
		logic [SEQ_W-1:0] seq_m1;
		logic             is_fin;
		logic             corrupt;
		logic             nonzero;
	} seg_cls_t;

endpackage

>>> sv/selective_repeat_sack_receiver_unit.sv
// Selective-repeat receiver with SACK. Each seg transaction is one segment header and
// yields one ack transaction, or none once an in-order FIN has finished the transfer. A
// two-entry queue sits behind seg_ready, so headers keep flowing while an ack waits on
// ack_ready. Corrupt and above-window segments are acked from the idle state, out-of-order
// segments read and rewrite one map row, and in-order segments scan the map a 32-slot row
// at a time for the next expected slot, over at most ceil(WINDOW_SIZE/32) rows, then wait
// on the remainder unit that locates that slot in the window. Per-row valid bits clear the
// map at reset and on flush, so no clearing pass is needed.
`timescale 1ns / 1ps

module selective_repeat_sack_receiver_unit #(
	parameter int WINDOW_SIZE = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           seg_valid,
	output logic           seg_ready,
	input  srsr_pkg::seg_t seg,
	output logic           ack_valid,
	input  logic           ack_ready,
	output srsr_pkg::ack_t ack
);

	logic               head_valid;
	logic               head_pop;
	srsr_pkg::seg_cls_t head;

	srsr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.seg_valid  (seg_valid),
		.seg_ready  (seg_ready),
		.seg        (seg),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.head       (head)
	);

	srsr_back #(
		.WINDOW_SIZE(WINDOW_SIZE)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.head       (head),
		.ack_valid  (ack_valid),
		.ack_ready  (ack_ready),
		.ack        (ack)
	);

`ifndef ASSERT_OFF
	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		head_pop |-> head_valid)
		else $error("queue popped while empty");

	a_done_is_fin_ack: assert property (@(posedge clk) disable iff (!arst_n)
		ack_valid && ack.done_res |-> ack.fin_ack)
		else $error("done without fin ack");

	a_quiet_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		ack_valid && ack_ready && ack.done_res |=> !ack_valid)
		else $error("ack issued after transfer finished");
`endif

endmodule

>>> sv/srsr_front.sv
`timescale 1ns / 1ps

module srsr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                seg_valid,
	output logic                seg_ready,
	input  srsr_pkg::seg_t      seg,
	output logic                head_valid,
	input  logic                head_pop,
	output srsr_pkg::seg_cls_t  head
);

	localparam logic [1:0] FULL = 2'd2;

	srsr_pkg::seg_cls_t ent_q [2];
	srsr_pkg::seg_cls_t cls;
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         cnt_q;
	logic               push;
	logic               pop;

	assign seg_ready  = (cnt_q != FULL);
	assign head_valid = (cnt_q != 2'd0);
	assign push       = seg_valid && seg_ready;
	assign pop        = head_pop && head_valid;
	assign head       = ent_q[rd_ptr_q];

	always_comb begin
		cls.seq     = seg.seq_num;
		cls.seq_m1  = seg.seq_num - srsr_pkg::SEQ_W'(1);
		cls.is_fin  = seg.is_fin;
		cls.corrupt = !seg.crc_ok;
		cls.nonzero = (seg.seq_num != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= cls;
	end

endmodule

>>> sv/srsr_modw.sv
`timescale 1ns / 1ps

module srsr_modw #(
	parameter int WINDOW_SIZE = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [srsr_pkg::SEQ_W-1:0]    x,
	output logic                          done,
	output logic [$clog2(WINDOW_SIZE)-1:0] rem
);

	localparam int IDX_W = $clog2(WINDOW_SIZE);
	localparam int TW = IDX_W + 1;
	localparam logic [TW-1:0] DIV = TW'(WINDOW_SIZE);
	localparam logic [srsr_pkg::MOD_CNT_W-1:0] STEPS = srsr_pkg::MOD_CNT_W'(srsr_pkg::MOD_STEPS);
	localparam logic [srsr_pkg::MOD_CNT_W-1:0] LAST = srsr_pkg::MOD_CNT_W'(1);

	logic [srsr_pkg::MOD_SH_W-1:0]  sh_q;
	logic [IDX_W-1:0]               rem_q;
	logic [srsr_pkg::MOD_CNT_W-1:0] left_q;
	logic                           done_q;
	logic [IDX_W-1:0]               rem_nxt;
	logic [TW-1:0]                  t;

	// restoring remainder, one dividend bit per inner step
	always_comb begin
		rem_nxt = rem_q;
		t = '0;
		for (int j = 0; j < srsr_pkg::MOD_DIGIT; j++) begin
			t = {rem_nxt, sh_q[srsr_pkg::MOD_SH_W-1-j]};
			if (t >= DIV) t = t - DIV;
			rem_nxt = t[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				left_q <= STEPS;
			end else if (left_q != '0) begin
				left_q <= left_q - LAST;
				if (left_q == LAST) done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= srsr_pkg::MOD_SH_W'(x);
			rem_q <= '0;
		end else if (left_q != '0) begin
			sh_q  <= sh_q << srsr_pkg::MOD_DIGIT;
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

>>> sv/srsr_back.sv
`timescale 1ns / 1ps

module srsr_back #(
	parameter int WINDOW_SIZE = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	output logic               head_pop,
	input  srsr_pkg::seg_cls_t head,
	output logic               ack_valid,
	input  logic               ack_ready,
	output srsr_pkg::ack_t     ack
);

	localparam int W = WINDOW_SIZE;
	localparam int SEQ_W = srsr_pkg::SEQ_W;
	localparam int IDX_W = $clog2(W);
	localparam int CNT_W = $clog2(W + 1);
	localparam int RB = srsr_pkg::ROW_BITS;
	localparam int RS = srsr_pkg::ROW_SH;
	localparam int ROWS = (W + RB - 1) / RB;
	localparam int RA_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int EW = RA_W + RS;
	localparam int IW = EW + 1;
	localparam int BASE_W = IDX_W + srsr_pkg::WC_W;
	localparam int LW = BASE_W + 1;
	localparam int CW = (LW > SEQ_W) ? LW : SEQ_W;
	localparam logic [RA_W-1:0] LAST_ROW = RA_W'(ROWS - 1);
	localparam logic [CNT_W-1:0] W_CNT = CNT_W'(W);
	localparam logic [srsr_pkg::DLV_W-1:0] W_DLV = srsr_pkg::DLV_W'(W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OOO,
		ST_MARK,
		ST_SCAN,
		ST_MOD
	} state_t;

	state_t                          state_q;
	logic [SEQ_W-1:0]                ne_q;
	logic [IDX_W-1:0]                off_q;
	logic [BASE_W-1:0]               base_q;
	logic [LW-1:0]                   lim_q;
	logic [srsr_pkg::WC_W-1:0]       wc_q;
	logic                            fin_q;
	logic [CNT_W-1:0]                cnt_q;
	logic [ROWS-1:0]                 rv_q;
	logic                            out_v_q;
	srsr_pkg::ack_t                  out_q;

	srsr_pkg::seg_cls_t              cur_q;
	logic                            mk_q;
	logic [RA_W-1:0]                 row_q;
	logic [RS-1:0]                   sb_q;
	logic [SEQ_W-1:0]                x_q;
	logic [RB-1:0]                   mem_q [ROWS];
	logic [RB-1:0]                   rdata_q;

	logic                            slot_free;
	logic                            take;
	logic                            in_order;
	logic                            above;
	logic                            in_win;
	logic                            drop;
	logic [CW-1:0]                   ooo_off;
	logic [IDX_W-1:0]                sel_idx;
	logic [EW-1:0]                   sel_e;
	logic [RA_W-1:0]                 rd_addr;
	logic [RB-1:0]                   row_v;
	logic [RB-1:0]                   row_m;
	logic                            marking;
	logic                            wr_en;
	logic                            bit_was;
	logic                            found;
	logic [RS-1:0]                   pos;
	logic [IW-1:0]                   hit_e;
	logic [CNT_W-1:0]                scan_i;
	logic                            scan_end;
	logic [CW-1:0]                   adv_sum;
	logic [SEQ_W-1:0]                adv_x;
	logic [SEQ_W-1:0]                ne_m1;
	logic                            mod_start;
	logic                            mod_done;
	logic [IDX_W-1:0]                mod_rem;
	logic [31:0]                     rem_ext;
	logic [srsr_pkg::DLV_W-1:0]      dlv;
	logic                            flush;
	logic [BASE_W-1:0]               base_nxt;

	assign slot_free = !out_v_q || ack_ready;
	assign take      = (state_q == ST_IDLE) && head_valid && !fin_q && slot_free;
	assign head_pop  = (state_q == ST_IDLE) && head_valid && (fin_q || slot_free);

	// classify the queue head against the current window
	assign in_order = (head.seq == ne_q);
	assign above    = (CW'(head.seq) > CW'(lim_q));
	assign in_win   = head.nonzero && (CW'(head.seq_m1) >= CW'(base_q));
	assign drop     = head.corrupt || (!in_order && above);
	assign ooo_off  = CW'(head.seq_m1) - CW'(base_q);
	assign sel_idx  = (in_order || !in_win) ? off_q : ooo_off[IDX_W-1:0];
	assign sel_e    = EW'(sel_idx);
	assign ne_m1    = ne_q - SEQ_W'(1);

	// rows never written since the last flush read as empty
	assign row_v   = rv_q[row_q] ? rdata_q : '0;
	assign marking = ((state_q == ST_MARK) || (state_q == ST_OOO)) && mk_q;
	assign row_m   = marking ? (row_v | (RB'(1) << sb_q)) : row_v;
	assign bit_was = row_v[sb_q];
	assign wr_en   = marking;

	// first empty slot at or above the start bit of this row
	always_comb begin
		found = 1'b0;
		pos   = '0;
		for (int p = RB - 1; p >= 0; p--) begin
			if (!row_m[p] && (RS'(p) >= sb_q)) begin
				found = 1'b1;
				pos   = RS'(p);
			end
		end
	end

	assign hit_e    = IW'({row_q, pos});
	assign scan_i   = (found && (hit_e < IW'(W))) ? CNT_W'(hit_e) : W_CNT;
	assign scan_end = found || (row_q == LAST_ROW);
	assign adv_sum  = CW'(scan_i) + CW'(base_q);
	assign adv_x    = adv_sum[SEQ_W-1:0];
	assign mod_start = ((state_q == ST_MARK) || (state_q == ST_SCAN)) && scan_end;

	always_comb begin
		case (state_q)
			ST_IDLE: rd_addr = sel_e[EW-1:RS];
			ST_MARK, ST_SCAN: rd_addr = scan_end ? row_q : row_q + RA_W'(1);
			default: rd_addr = row_q;
		endcase
	end

	assign rem_ext  = 32'(mod_rem);
	assign dlv      = (mod_rem == '0) ? W_DLV : rem_ext[srsr_pkg::DLV_W-1:0];
	assign flush    = cur_q.is_fin || (cnt_q == W_CNT);
	assign base_nxt = (wc_q == '1) ? '0 : base_q + BASE_W'(W);

	srsr_modw #(
		.WINDOW_SIZE(WINDOW_SIZE)
	) u_modw (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.x      (adv_x),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ne_q    <= SEQ_W'(1);
			off_q   <= '0;
			base_q  <= '0;
			lim_q   <= LW'(W);
			wc_q    <= '0;
			fin_q   <= 1'b0;
			cnt_q   <= '0;
			rv_q    <= '0;
			out_v_q <= 1'b0;
			out_q   <= '0;
		end else begin
			if (ack_ready) out_v_q <= 1'b0;
			if (wr_en) begin
				rv_q[row_q] <= 1'b1;
				if (!bit_was) cnt_q <= cnt_q + CNT_W'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (drop) begin
							out_v_q               <= 1'b1;
							out_q.ack_num         <= ne_m1;
							out_q.sack_num        <= ne_m1;
							out_q.fin_ack         <= 1'b0;
							out_q.delivered_count <= '0;
							out_q.done_res        <= 1'b0;
						end else if (in_order) begin
							state_q <= ST_MARK;
						end else begin
							state_q <= ST_OOO;
						end
					end
				end
				ST_OOO: begin
					out_v_q               <= 1'b1;
					out_q.ack_num         <= ne_m1;
					out_q.sack_num        <= cur_q.seq;
					out_q.fin_ack         <= cur_q.is_fin;
					out_q.delivered_count <= '0;
					out_q.done_res        <= 1'b0;
					state_q               <= ST_IDLE;
				end
				ST_MARK, ST_SCAN: begin
					state_q <= scan_end ? ST_MOD : ST_SCAN;
				end
				ST_MOD: begin
					if (mod_done) begin
						off_q                 <= mod_rem;
						ne_q                  <= x_q + SEQ_W'(1);
						out_v_q               <= 1'b1;
						out_q.ack_num         <= x_q;
						out_q.sack_num        <= cur_q.seq;
						out_q.fin_ack         <= cur_q.is_fin;
						out_q.delivered_count <= flush ? dlv : '0;
						out_q.done_res        <= cur_q.is_fin;
						if (cur_q.is_fin) fin_q <= 1'b1;
						if (flush) begin
							rv_q   <= '0;
							cnt_q  <= '0;
							wc_q   <= wc_q + srsr_pkg::WC_W'(1);
							base_q <= base_nxt;
							lim_q  <= LW'(base_nxt) + LW'(W);
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					cur_q <= head;
					mk_q  <= in_win;
					row_q <= sel_e[EW-1:RS];
					sb_q  <= sel_e[RS-1:0];
				end
			end
			ST_MARK, ST_SCAN: begin
				if (scan_end) begin
					x_q <= adv_x;
				end else begin
					row_q <= row_q + RA_W'(1);
					sb_q  <= '0;
				end
			end
			default: ;
		endcase
	end

	// map rows: one registered read each cycle, one write in cycles that mark a slot
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[rd_addr];
		if (wr_en) mem_q[row_q] <= row_m;
	end

	assign ack_valid = out_v_q;
	assign ack       = out_q;

endmodule
